// File: hdl/mfsr_pkg.sv
// ----------------------------------------------------------------------------
// mfsr_pkg
// Types, codes and character constants shared by the frame reassembler.
// ----------------------------------------------------------------------------
`default_nettype none

package mfsr_pkg;

  localparam int MAX_FRAMES_DEF = 32;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;
  localparam int FRAMES_W = 6;

  // ascii characters of the frame header
  localparam logic [7:0] SEQ_BASE    = 8'h30;
  localparam logic [7:0] SEQ_FIRST   = 8'h31;
  localparam logic [7:0] GROUP_CFG   = 8'h30;
  localparam logic [7:0] GROUP_HIGH  = 8'h31;
  localparam logic [7:0] GROUP_DATA  = 8'h32;
  localparam logic [7:0] SEQ_HIGH_ADJ = 8'h10;
  localparam logic [7:0] TYPE_SINGLE_LO = 8'h31;
  localparam logic [7:0] TYPE_SINGLE_HI = 8'h34;
  localparam logic [7:0] TYPE_DOUBLE_LO = 8'h35;
  localparam logic [7:0] TYPE_DOUBLE_HI = 8'h38;

  // register reset values
  localparam logic [7:0] STATION_RST = 8'd3;
  localparam logic [7:0] FUNCTION_RST = 8'd16;
  localparam logic [FRAMES_W-1:0] SINGLE_CFG_RST = 6'd13;
  localparam logic [FRAMES_W-1:0] DOUBLE_CFG_RST = 6'd19;
  localparam logic [FRAMES_W-1:0] SINGLE_DATA_RST = 6'd2;
  localparam logic [FRAMES_W-1:0] DOUBLE_DATA_RST = 6'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STATION     = 3'd0,
    REG_FUNCTION    = 3'd1,
    REG_SINGLE_CFG  = 3'd2,
    REG_DOUBLE_CFG  = 3'd3,
    REG_SINGLE_DATA = 3'd4,
    REG_DOUBLE_DATA = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ACT_IGNORED   = 3'd0,
    ACT_FIRST     = 3'd1,
    ACT_NEXT      = 3'd2,
    ACT_DUPLICATE = 3'd3,
    ACT_BAD_TYPE  = 3'd4,
    ACT_SEQ_RESET = 3'd5,
    ACT_OVERRUN   = 3'd6
  } action_t;

  typedef enum logic [2:0] {
    MODE_NONE        = 3'd0,
    MODE_SINGLE_CFG  = 3'd1,
    MODE_DOUBLE_CFG  = 3'd2,
    MODE_SINGLE_DATA = 3'd3,
    MODE_DOUBLE_DATA = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    KIND_SINGLE_CFG  = 2'd0,
    KIND_DOUBLE_CFG  = 2'd1,
    KIND_SINGLE_DATA = 2'd2,
    KIND_DOUBLE_DATA = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] station_byte;
    logic [7:0] function_byte;
    logic [7:0] group_char;
    logic [7:0] sequence_char;
    logic [7:0] type_char;
  } frame_t;

  typedef struct packed {
    logic          acknowledge;
    action_t       action;
    logic          store_enable;
    logic [4:0]    slot_index;
    logic          message_complete;
    kind_t         message_kind;
  } result_t;

  typedef struct packed {
    logic [7:0]          station_address;
    logic [7:0]          function_code;
    logic [FRAMES_W-1:0] single_config_frames;
    logic [FRAMES_W-1:0] double_config_frames;
    logic [FRAMES_W-1:0] single_data_frames;
    logic [FRAMES_W-1:0] double_data_frames;
  } cfg_t;

endpackage

`default_nettype wire

// File: hdl/mfsr_if.sv
// ----------------------------------------------------------------------------
// mfsr_if
// Valid/ready channel interfaces for frame headers, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfsr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] station_byte;
  logic [7:0] function_byte;
  logic [7:0] group_char;
  logic [7:0] sequence_char;
  logic [7:0] type_char;

  modport source (output valid, station_byte, function_byte, group_char,
                  sequence_char, type_char, input ready);
  modport sink (input valid, station_byte, function_byte, group_char,
                sequence_char, type_char, output ready);
endinterface

interface mfsr_out_if;
  logic       valid;
  logic       ready;
  logic       acknowledge;
  logic [2:0] action;
  logic       store_enable;
  logic [4:0] slot_index;
  logic       message_complete;
  logic [1:0] message_kind;

  modport source (output valid, acknowledge, action, store_enable, slot_index,
                  message_complete, message_kind, input ready);
  modport sink (input valid, acknowledge, action, store_enable, slot_index,
                message_complete, message_kind, output ready);
endinterface

interface mfsr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mfsr_pkg::CFG_IDX_W-1:0]  index;
  logic [mfsr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/mfsr_cfg_regs.sv
// ----------------------------------------------------------------------------
// mfsr_cfg_regs
// Address match and message length registers, written over the config channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mfsr_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  mfsr_cfg_if.sink         cfg,
  output mfsr_pkg::cfg_t   regs
);

  mfsr_pkg::cfg_t regs_r;
  mfsr_pkg::cfg_t regs_nxt;

  assign cfg.ready = 1'b1;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg.valid) begin
      unique case (cfg.index)
        mfsr_pkg::REG_STATION:     regs_nxt.station_address = cfg.data;
        mfsr_pkg::REG_FUNCTION:    regs_nxt.function_code = cfg.data;
        mfsr_pkg::REG_SINGLE_CFG:
          regs_nxt.single_config_frames = cfg.data[mfsr_pkg::FRAMES_W-1:0];
        mfsr_pkg::REG_DOUBLE_CFG:
          regs_nxt.double_config_frames = cfg.data[mfsr_pkg::FRAMES_W-1:0];
        mfsr_pkg::REG_SINGLE_DATA:
          regs_nxt.single_data_frames = cfg.data[mfsr_pkg::FRAMES_W-1:0];
        mfsr_pkg::REG_DOUBLE_DATA:
          regs_nxt.double_data_frames = cfg.data[mfsr_pkg::FRAMES_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.station_address      <= mfsr_pkg::STATION_RST;
      regs_r.function_code        <= mfsr_pkg::FUNCTION_RST;
      regs_r.single_config_frames <= mfsr_pkg::SINGLE_CFG_RST;
      regs_r.double_config_frames <= mfsr_pkg::DOUBLE_CFG_RST;
      regs_r.single_data_frames   <= mfsr_pkg::SINGLE_DATA_RST;
      regs_r.double_data_frames   <= mfsr_pkg::DOUBLE_DATA_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

`default_nettype wire

// File: hdl/mfsr_tracker.sv
// ----------------------------------------------------------------------------
// mfsr_tracker
// Per-frame header decision and message state (mode, expected sequence).
// ----------------------------------------------------------------------------
`default_nettype none

module mfsr_tracker #(
  parameter int MAX_FRAMES = mfsr_pkg::MAX_FRAMES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step,
  input  mfsr_pkg::frame_t  frame,
  input  mfsr_pkg::cfg_t    regs,
  output mfsr_pkg::result_t res
);

  mfsr_pkg::mode_t mode_r;
  mfsr_pkg::mode_t mode_nxt;
  logic [7:0]      exp_r;
  logic [7:0]      exp_nxt;

  logic                          addressed;
  logic                          first_frame;
  logic                          type_single;
  logic                          type_double;
  logic [7:0]                    adj_seq;
  logic [8:0]                    slot_diff;
  logic                          check;
  logic [mfsr_pkg::FRAMES_W-1:0] frames;
  logic [7:0]                    limit;

  assign addressed = (frame.station_byte == regs.station_address) &&
                     (frame.function_byte == regs.function_code);
  assign first_frame = ((frame.group_char == mfsr_pkg::GROUP_CFG) ||
                        (frame.group_char == mfsr_pkg::GROUP_DATA)) &&
                       (frame.sequence_char == mfsr_pkg::SEQ_BASE);
  assign type_single = (frame.type_char >= mfsr_pkg::TYPE_SINGLE_LO) &&
                       (frame.type_char <= mfsr_pkg::TYPE_SINGLE_HI);
  assign type_double = (frame.type_char >= mfsr_pkg::TYPE_DOUBLE_LO) &&
                       (frame.type_char <= mfsr_pkg::TYPE_DOUBLE_HI);
  assign adj_seq = (frame.group_char == mfsr_pkg::GROUP_HIGH) ?
                   frame.sequence_char + mfsr_pkg::SEQ_HIGH_ADJ : frame.sequence_char;
  // bit 8 set means expected sequence sits below the base character
  assign slot_diff = {1'b0, exp_r} - {1'b0, mfsr_pkg::SEQ_BASE};

  always_comb begin
    res      = '0;
    mode_nxt = mode_r;
    exp_nxt  = exp_r;
    check    = 1'b1;
    frames   = '0;
    limit    = '0;
    if (addressed) begin
      res.acknowledge = 1'b1;
      if (first_frame) begin
        if (type_single || type_double) begin
          if (frame.group_char == mfsr_pkg::GROUP_CFG) begin
            mode_nxt = type_double ? mfsr_pkg::MODE_DOUBLE_CFG : mfsr_pkg::MODE_SINGLE_CFG;
          end else begin
            mode_nxt = type_double ? mfsr_pkg::MODE_DOUBLE_DATA : mfsr_pkg::MODE_SINGLE_DATA;
          end
          exp_nxt          = mfsr_pkg::SEQ_FIRST;
          res.action       = mfsr_pkg::ACT_FIRST;
          res.store_enable = 1'b1;
        end else begin
          res.action = mfsr_pkg::ACT_BAD_TYPE;
        end
      end else if (adj_seq == exp_r) begin
        if (slot_diff[8] || (slot_diff[7:0] >= 8'(MAX_FRAMES))) begin
          mode_nxt   = mfsr_pkg::MODE_NONE;
          exp_nxt    = mfsr_pkg::SEQ_BASE;
          res.action = mfsr_pkg::ACT_OVERRUN;
          check      = 1'b0;
        end else begin
          res.store_enable = 1'b1;
          res.slot_index   = slot_diff[4:0];
          exp_nxt          = exp_r + 8'd1;
          res.action       = mfsr_pkg::ACT_NEXT;
        end
      end else if (adj_seq == exp_r - 8'd1) begin
        res.action = mfsr_pkg::ACT_DUPLICATE;
      end else begin
        mode_nxt   = mfsr_pkg::MODE_NONE;
        exp_nxt    = mfsr_pkg::SEQ_BASE;
        res.action = mfsr_pkg::ACT_SEQ_RESET;
        check      = 1'b0;
      end

      // completion against the frame count of the open message
      if (check && (mode_nxt != mfsr_pkg::MODE_NONE)) begin
        unique case (mode_nxt)
          mfsr_pkg::MODE_SINGLE_CFG:  frames = regs.single_config_frames;
          mfsr_pkg::MODE_DOUBLE_CFG:  frames = regs.double_config_frames;
          mfsr_pkg::MODE_SINGLE_DATA: frames = regs.single_data_frames;
          default:                    frames = regs.double_data_frames;
        endcase
        limit = mfsr_pkg::SEQ_BASE + {2'b00, frames};
        if (exp_nxt == limit) begin
          res.message_complete = 1'b1;
          case (mode_nxt)
            mfsr_pkg::MODE_SINGLE_CFG:  res.message_kind = mfsr_pkg::KIND_SINGLE_CFG;
            mfsr_pkg::MODE_DOUBLE_CFG:  res.message_kind = mfsr_pkg::KIND_DOUBLE_CFG;
            mfsr_pkg::MODE_SINGLE_DATA: res.message_kind = mfsr_pkg::KIND_SINGLE_DATA;
            default:                    res.message_kind = mfsr_pkg::KIND_DOUBLE_DATA;
          endcase
          mode_nxt = mfsr_pkg::MODE_NONE;
          exp_nxt  = mfsr_pkg::SEQ_BASE;
        end else if (exp_nxt > limit) begin
          mode_nxt         = mfsr_pkg::MODE_NONE;
          exp_nxt          = mfsr_pkg::SEQ_BASE;
          res.action       = mfsr_pkg::ACT_OVERRUN;
          res.store_enable = 1'b0;
          res.slot_index   = 5'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= mfsr_pkg::MODE_NONE;
      exp_r  <= mfsr_pkg::SEQ_BASE;
    end else if (step) begin
      mode_r <= mode_nxt;
      exp_r  <= exp_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/multi_frame_sequence_reassembler.sv
// ----------------------------------------------------------------------------
// multi_frame_sequence_reassembler
// Header filter and sequence tracker for multi-frame bus messages.
// ----------------------------------------------------------------------------
// Takes one frame header per beat and returns one result beat per frame. A new
// header is accepted every cycle unless the result side stalls; a result passes
// through the input register, then the decision logic and message state update,
// then the result register. Throughput is one frame per cycle, set by the
// single decision stage that reads and writes the message state. Stalls on the
// result side hold both registers and back-pressure the input. Register writes
// are taken every cycle and must only happen while no frame is in flight.
`default_nettype none

module multi_frame_sequence_reassembler #(
  parameter int MAX_FRAMES = mfsr_pkg::MAX_FRAMES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mfsr_in_if.sink    in_ch,
  mfsr_out_if.source out_ch,
  mfsr_cfg_if.sink   cfg_ch
);

  mfsr_pkg::cfg_t    regs;
  mfsr_pkg::frame_t  in_frame_r;
  logic              in_valid_r;
  logic              in_valid_nxt;
  mfsr_pkg::result_t res;
  mfsr_pkg::result_t out_res_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              advance;
  logic              in_take;

  mfsr_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_ch),
    .regs  (regs)
  );

  mfsr_tracker #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_trk (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .frame (in_frame_r),
    .regs  (regs),
    .res   (res)
  );

  // decision stage fires when the result register is free or being emptied
  assign advance = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take = in_ch.valid && in_ch.ready;

  assign in_valid_nxt = in_take || (in_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_frame_r.station_byte  <= in_ch.station_byte;
      in_frame_r.function_byte <= in_ch.function_byte;
      in_frame_r.group_char    <= in_ch.group_char;
      in_frame_r.sequence_char <= in_ch.sequence_char;
      in_frame_r.type_char     <= in_ch.type_char;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.acknowledge      = out_res_r.acknowledge;
  assign out_ch.action           = out_res_r.action;
  assign out_ch.store_enable     = out_res_r.store_enable;
  assign out_ch.slot_index       = out_res_r.slot_index;
  assign out_ch.message_complete = out_res_r.message_complete;
  assign out_ch.message_kind     = out_res_r.message_kind;

endmodule

`default_nettype wire
